>>> hdl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values and round helper functions.
// ----------------------------------------------------------------------------
`default_nettype none
package sha256_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned DigestWords = 8;
  localparam logic [7:0]  PadByte    = 8'h80;

  typedef logic [31:0] word_t;

  localparam word_t InitWords [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t sig0(input word_t x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig1(input word_t x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PAD   = 7'b0000010,
    ST_LOAD  = 7'b0000100,
    ST_ROUND = 7'b0001000,
    ST_ADD   = 7'b0010000,
    ST_EMIT  = 7'b0100000,
    ST_PAD2  = 7'b1000000
  } state_t;

endpackage
`default_nettype wire

>>> hdl/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream with one shared round unit; emits eight digest words.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                                    | Direction
//  --------+------------------------------------------+----------
//  input   | in_valid, in_stall, in_data_byte,        | in
//          | in_has_byte, in_last                     |
//  result  | out_valid, out_stall, out_digest_word,   | out
//          | out_word_index, out_last_word            |
//
// A word that neither completes a block nor is last leaves the sequencer idle. A
// word that completes a block passes through the load, round and add states.
// A last word writes the padding one byte per cycle from the fill point to the
// end of the block, runs one or two compressions, then presents the eight
// digest words, one per cycle while out_stall is low.
// Reset restores the initial hash values and clears the byte count; in_stall
// is high whenever the sequencer is not idle.
`default_nettype none
module sha256_stream_hasher
  import sha256_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_has_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);

  state_t      state_r, state_nxt;
  word_t       chain_r [8];
  word_t       hv_r [8];            // a..h
  word_t       w_r [16];            // rolling schedule window
  word_t       buf_r [16];          // block buffer, big-endian bytes per word
  logic [60:0] count_r;
  logic [5:0]  ptr_r;               // padding write position
  logic [5:0]  rnd_r;
  logic [2:0]  oidx_r;
  logic        fin_r;               // compression belongs to finalization
  logic        two_r;               // first of two final blocks
  logic        go;

  assign in_stall = (state_r != ST_IDLE);
  assign go       = in_valid && (state_r == ST_IDLE);

  // Byte the padding sweep writes at ptr_r: 0x80 at the fill point, the
  // length bytes in the last eight slots of the final block, zeros elsewhere.
  logic [63:0] bits;
  logic [7:0]  pad_byte;
  assign bits = {count_r, 3'b000};
  always_comb begin
    pad_byte = 8'h00;
    if (state_r == ST_PAD && ptr_r == count_r[5:0]) begin
      pad_byte = PadByte;
    end else if (!two_r && ptr_r[5:3] == 3'b111) begin
      pad_byte = bits[8 * (7 - ptr_r[2:0]) +: 8];
    end
  end

  // Round datapath.
  word_t w_cur, t1, t2;
  always_comb begin
    if (rnd_r[5:4] == 2'b00) begin
      w_cur = w_r[rnd_r[3:0]];
    end else begin
      w_cur = w_r[rnd_r[3:0]] + sig1(w_r[rnd_r[3:0] - 4'd2])
            + w_r[rnd_r[3:0] - 4'd7] + sig0(w_r[rnd_r[3:0] - 4'd15]);
    end
    t1 = hv_r[7] + bsig1(hv_r[4]) + ((hv_r[4] & hv_r[5]) ^ (~hv_r[4] & hv_r[6]))
       + RoundK[rnd_r] + w_cur;
    t2 = bsig0(hv_r[0])
       + ((hv_r[0] & hv_r[1]) ^ (hv_r[0] & hv_r[2]) ^ (hv_r[1] & hv_r[2]));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (go) begin
          if (in_has_byte && count_r[5:0] == 6'd63) begin
            state_nxt = ST_LOAD;
          end else if (in_last) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD:   if (ptr_r == 6'd63) state_nxt = ST_LOAD;
      ST_PAD2:  if (ptr_r == 6'd63) state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_ROUND;
      ST_ROUND: if (rnd_r == 6'd63) state_nxt = ST_ADD;
      ST_ADD: begin
        if (fin_r && two_r)  state_nxt = ST_PAD2;
        else if (fin_r)      state_nxt = ST_EMIT;
        else if (two_r)      state_nxt = ST_PAD;   // last word filled a block
        else                 state_nxt = ST_IDLE;
      end
      ST_EMIT:  if (!out_stall && oidx_r == 3'd7) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Buffer writes, the schedule load and the round updates.
  always_ff @(posedge clk) begin
    if (go && in_has_byte) begin
      buf_r[count_r[5:2]][8 * (3 - count_r[1:0]) +: 8] <= in_data_byte;
    end
    if (state_r == ST_PAD || state_r == ST_PAD2) begin
      if (state_r == ST_PAD2 || ptr_r >= count_r[5:0]) begin
        buf_r[ptr_r[5:2]][8 * (3 - ptr_r[1:0]) +: 8] <= pad_byte;
      end
    end
    if (state_r == ST_LOAD) begin
      for (int i = 0; i < 16; i++) w_r[i] <= buf_r[i];
      for (int i = 0; i < 8; i++) hv_r[i] <= chain_r[i];
    end
    if (state_r == ST_ROUND) begin
      w_r[rnd_r[3:0]] <= w_cur;
      hv_r[0] <= t1 + t2;
      hv_r[1] <= hv_r[0];
      hv_r[2] <= hv_r[1];
      hv_r[3] <= hv_r[2];
      hv_r[4] <= hv_r[3] + t1;
      hv_r[5] <= hv_r[4];
      hv_r[6] <= hv_r[5];
      hv_r[7] <= hv_r[6];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ptr_r   <= '0;
      rnd_r   <= '0;
      oidx_r  <= '0;
      fin_r   <= 1'b0;
      two_r   <= 1'b0;
      for (int i = 0; i < 8; i++) chain_r[i] <= InitWords[i];
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (go) begin
            if (in_has_byte) count_r <= count_r + 61'd1;
            fin_r  <= in_last && !(in_has_byte && count_r[5:0] == 6'd63);
            // On a block-completing byte two_r flags a pending last item;
            // otherwise it marks a fill point too late for the length field.
            two_r  <= in_last && ((in_has_byte && count_r[5:0] == 6'd63) ||
                      ((in_has_byte ? count_r[5:0] + 6'd1 : count_r[5:0]) > 6'd55));
            ptr_r  <= in_has_byte ? count_r[5:0] + 6'd1 : count_r[5:0];
          end
        end
        ST_PAD, ST_PAD2: begin
          ptr_r <= ptr_r + 6'd1;
          if (ptr_r == 6'd63) rnd_r <= '0;
        end
        ST_ROUND: rnd_r <= rnd_r + 6'd1;
        ST_ADD: begin
          for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + hv_r[i];
          ptr_r <= '0;
          if (fin_r && two_r) begin
            two_r <= 1'b0;
          end else if (!fin_r && two_r) begin
            fin_r <= 1'b1;
            two_r <= 1'b0;  // fill is zero after a full block
          end
          oidx_r <= '0;
        end
        ST_EMIT: begin
          if (!out_stall) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              for (int i = 0; i < 8; i++) chain_r[i] <= InitWords[i];
              count_r <= '0;
              fin_r   <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid       = (state_r == ST_EMIT);
  assign out_digest_word = chain_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'd7);

  ap_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("input accepted while busy");
  ap_emit_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_word) |=> (state_r == ST_IDLE))
    else $error("sequencer did not return to idle after digest");
  ap_round_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && rnd_r == 6'd63) |=> (state_r == ST_ADD))
    else $error("compression did not end after 64 rounds");

endmodule
`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Feeds byte streams with empty, finalize-only and last words, predicts each
// digest with a behavioral SHA-256 and checks every digest word in order.
// ----------------------------------------------------------------------------
module testbench;
  import sha256_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_has_byte;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  sha256_stream_hasher u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data_byte(in_data_byte),
    .in_has_byte(in_has_byte), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_last_word(out_last_word)
  );

  // One expected digest word with its position and end marker.
  typedef struct packed {
    logic [31:0] dword;
    logic [2:0]  idx;
    logic        lastw;
  } digest_word_t;

  digest_word_t pending_words[$];

  // Predictor state: chaining words, partial block and the 61-bit byte count.
  word_t       hash_state [8];
  logic [7:0]  partial_block [64];
  logic [60:0] byte_count;

  int  mismatches;
  bit  idle_enable;
  longint cycle_count;
  localparam longint CycleLimit = 400000;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic word_t ror32(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One 64-round compression of the partial block into the chaining words.
  task automatic compress_partial_block();
    word_t w [64];
    word_t v [8];
    word_t t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {partial_block[4*t], partial_block[4*t+1], partial_block[4*t+2],
              partial_block[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = w[t-16] + (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10))
           + w[t-7] + (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3));
    v = hash_state;
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + w[t];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) hash_state[j] += v[j];
  endtask

  // Advances the predicted hasher by one accepted word and queues any digest.
  task automatic predict_digest(logic [7:0] b, logic hb, logic lst);
    int fill;
    logic [63:0] bits;
    if (hb) begin
      partial_block[byte_count[5:0]] = b;
      byte_count = byte_count + 61'd1;
      if (byte_count[5:0] == 0) compress_partial_block();
    end
    if (lst) begin
      fill = int'(byte_count[5:0]);
      partial_block[fill] = PadByte;
      for (int j = fill + 1; j < 64; j++) partial_block[j] = 8'h00;
      if (fill > 55) begin
        compress_partial_block();
        for (int j = 0; j < 64; j++) partial_block[j] = 8'h00;
      end
      bits = {byte_count, 3'b000};
      for (int j = 0; j < 8; j++) partial_block[56+j] = bits[63-8*j -: 8];
      compress_partial_block();
      for (int j = 0; j < 8; j++)
        pending_words.push_back('{hash_state[j], 3'(j), j == 7});
      hash_state = InitWords;
      byte_count = '0;
    end
  endtask

  // Sends one word, with random gaps, and predicts it once it is accepted.
  // in_valid stays high after acceptance; the next call or the end of the
  // run drives it in the same time step.
  task automatic send_word(logic [7:0] b, logic hb, logic lst);
    while (idle_enable && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_has_byte  <= hb;
    in_last      <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_digest(b, hb, lst);
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) send_word(8'($urandom), 1'b1, i == len - 1);
  endtask

  // Result side: random stall, compared against the oldest expectation.
  always @(posedge clk) begin
    digest_word_t exp_w;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected digest word %h", out_digest_word);
        end else begin
          exp_w = pending_words.pop_front();
          if (exp_w != {out_digest_word, out_word_index, out_last_word}) begin
            mismatches++;
            if (mismatches <= 10)
              $display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                       exp_w.dword, exp_w.idx, exp_w.lastw,
                       out_digest_word, out_word_index, out_last_word);
          end
        end
      end
      out_stall <= idle_enable && ($urandom_range(99) < 24);
    end
  end

  // Extremes: empty message, single bytes 0x00 and 0xFF, idle words.
  task automatic test_edge_values();
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'hFF, 1'b1, 1'b1);
    send_word(8'h5A, 1'b0, 1'b0);
    send_word(8'hA5, 1'b1, 1'b0);
    send_word(8'h3C, 1'b0, 1'b0);
    send_word(8'hC3, 1'b0, 1'b1);
  endtask

  // Padding boundaries: 56 bytes needs two final blocks, 64 pads into a
  // fresh block after a full compression.
  task automatic test_pad_boundaries();
    send_message(56);
    send_message(64);
  endtask

  // A stretch with no gaps on either side.
  task automatic test_back_to_back();
    idle_enable = 1'b0;
    send_message(20);
    idle_enable = 1'b1;
  endtask

  // Length wrap: the 61-bit count is not reachable by streaming, so the
  // predictor covers it only through the same arithmetic; nothing to drive.

  // Random short messages with empty and finalize-only words.
  task automatic test_random_streams();
    int sent;
    sent = 0;
    while (sent < 16) begin
      int len;
      len = $urandom_range(6);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(9) == 0) send_word(8'($urandom), 1'b0, 1'b0);
        send_word(8'($urandom), 1'b1, 1'b0);
        sent++;
      end
      send_word(8'($urandom), 1'($urandom), 1'b1);
      sent++;
    end
  endtask

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; in_data_byte = '0; in_has_byte = 1'b0;
    in_last = 1'b0; out_stall = 1'b0; mismatches = 0; cycle_count = 0;
    idle_enable = 1'b1;
    hash_state = InitWords;
    byte_count = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_values();
    test_pad_boundaries();
    test_back_to_back();
    test_random_streams();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
